/* rtl/resync_backoff_timer_assert.svh */
// assertion macros shared by the resync back-off timer rtl
// depends on nothing; included by the top level only
`ifndef RESYNC_BACKOFF_TIMER_ASSERT_SVH
`define RESYNC_BACKOFF_TIMER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rbt_pkg.sv */
// types and constants for the resync back-off timer
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package rbt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_TIMEOUT  = 3'd0,
        CFG_RESYNC_WINDOW = 3'd1,
        CFG_WAIT_INITIAL  = 3'd2,
        CFG_WAIT_STEP     = 3'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_RESYNC = 2'd1,
        ACT_OFF    = 2'd2
    } t_action;

    typedef struct packed {
        logic [6:0]        sync_timeout;
        logic [6:0]        resync_window;
        logic signed [7:0] wait_initial;
        logic [6:0]        wait_step;
    } t_cfg;

    typedef struct packed {
        logic signed [7:0] count;
        logic signed [7:0] backoff;
        logic              lost;
    } t_state;

    typedef struct packed {
        t_state  state;
        t_action action;
        logic    data_allowed;
    } t_result;

    localparam logic [6:0]        RST_SYNC_TIMEOUT  = 7'd60;
    localparam logic [6:0]        RST_RESYNC_WINDOW = 7'd1;
    localparam logic signed [7:0] RST_WAIT_INITIAL  = -8'sd10;
    localparam logic [6:0]        RST_WAIT_STEP     = 7'd5;

    // back-off never grows past this floor
    localparam logic signed [8:0] BACKOFF_FLOOR = -9'sd125;
    // countdown value while a resync listen is running
    localparam logic signed [7:0] COUNT_RESYNC  = -8'sd1;

endpackage

/* rtl/rbt_cfg_regs.sv */
// configuration registers of the resync back-off timer
// depends on rbt_pkg
`timescale 1ns / 1ps

module rbt_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rbt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rbt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rbt_pkg::t_cfg                   o_cfg
);

    rbt_pkg::t_cfg r_cfg;
    rbt_pkg::t_cfg n_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (rbt_pkg::t_cfg_idx'(i_cfg_index))
                rbt_pkg::CFG_SYNC_TIMEOUT:  n_cfg.sync_timeout  = i_cfg_data[6:0];
                rbt_pkg::CFG_RESYNC_WINDOW: n_cfg.resync_window = i_cfg_data[6:0];
                rbt_pkg::CFG_WAIT_INITIAL:  n_cfg.wait_initial  = $signed(i_cfg_data);
                rbt_pkg::CFG_WAIT_STEP:     n_cfg.wait_step     = i_cfg_data[6:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_timeout  <= rbt_pkg::RST_SYNC_TIMEOUT;
            r_cfg.resync_window <= rbt_pkg::RST_RESYNC_WINDOW;
            r_cfg.wait_initial  <= rbt_pkg::RST_WAIT_INITIAL;
            r_cfg.wait_step     <= rbt_pkg::RST_WAIT_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/rbt_update.sv */
// next-state and result logic for one tick or sync item
// depends on rbt_pkg
`timescale 1ns / 1ps

module rbt_update (
    input  rbt_pkg::t_cfg    i_cfg,
    input  rbt_pkg::t_state  i_state,
    input  logic             i_cmd,
    input  logic             i_radio_inoperable,
    output rbt_pkg::t_result o_result
);

    logic signed [7:0] dec;
    logic signed [8:0] dec_w;
    logic signed [8:0] bo_w;
    logic signed [8:0] step_w;
    logic signed [8:0] off_lim;
    logic signed [8:0] grow_lim;
    logic              at_or_below_zero;
    logic              past_backoff;
    logic              do_resync;
    logic              do_off;

    always_comb begin
        // 8-bit wrap on the decrement
        dec      = i_state.count - 8'sd1;
        dec_w    = {dec[7], dec};
        bo_w     = {i_state.backoff[7], i_state.backoff};
        step_w   = $signed({2'b00, i_cfg.wait_step});
        off_lim  = -9'sd1 - $signed({2'b00, i_cfg.resync_window});
        grow_lim = rbt_pkg::BACKOFF_FLOOR + step_w;

        at_or_below_zero = (dec <= 8'sd0);
        past_backoff     = (dec < i_state.backoff);
        do_resync        = at_or_below_zero && ((dec >= -8'sd1) || past_backoff);
        do_off           = at_or_below_zero && !do_resync && (dec_w <= off_lim);

        o_result.state  = i_state;
        o_result.action = rbt_pkg::ACT_NONE;

        if (i_cmd) begin
            o_result.state.count   = $signed({1'b0, i_cfg.sync_timeout});
            o_result.state.backoff = i_cfg.wait_initial;
            o_result.state.lost    = 1'b0;
        end else if (!i_radio_inoperable) begin
            o_result.state.count = dec;
            if (do_resync) begin
                if (past_backoff && (bo_w >= grow_lim)) begin
                    o_result.state.backoff = 8'(bo_w - step_w);
                end
                o_result.state.count = rbt_pkg::COUNT_RESYNC;
                o_result.action      = rbt_pkg::ACT_RESYNC;
            end else if (do_off) begin
                o_result.state.lost = 1'b1;
                o_result.action     = rbt_pkg::ACT_OFF;
            end
        end

        o_result.data_allowed = (o_result.state.count > 8'sd0);
    end

endmodule

/* rtl/resync_backoff_timer.sv */
// resync back-off timer: input register, state update and result register
// depends on rbt_pkg, rbt_cfg_regs, rbt_update and resync_backoff_timer_assert.svh
//
// usage
//   input channel: i_in_valid / o_in_stall with i_cmd (0 tick, 1 valid sync) and
//   i_radio_inoperable. a transfer happens when valid is high and stall is low.
//   output channel: o_out_valid / i_out_stall with o_action, o_sync_error,
//   o_data_allowed, o_countdown and o_backoff_limit, one result per input item.
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data,
//   index 0 sync_timeout, 1 resync_window, 2 wait_initial, 3 wait_step;
//   o_cfg_ready is always high. write only while the block is idle.
//   flow: an item lands in the input register, and the result register takes its
//   result once it is free (o_out_valid low or i_out_stall low).
//   throughput: one item per cycle while i_out_stall is low; the countdown and
//   back-off update is a single compare-and-add step between the two registers,
//   so items follow back to back.
//   stall: while the result waits, one more item is held in the input register;
//   after that o_in_stall rises.
//   reset (synchronous, active low): config and state registers return to their
//   defaults, countdown 0, back-off -10, sync error clear, both stages empty.
`timescale 1ns / 1ps

`include "resync_backoff_timer_assert.svh"

module resync_backoff_timer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic                            i_radio_inoperable,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_action,
    output logic                            o_sync_error,
    output logic                            o_data_allowed,
    output logic signed [7:0]               o_countdown,
    output logic signed [7:0]               o_backoff_limit,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rbt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rbt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    rbt_pkg::t_cfg    cfg;
    rbt_pkg::t_state  r_state;
    rbt_pkg::t_result upd;
    rbt_pkg::t_result r_out;

    logic r_in_valid;
    logic r_in_cmd;
    logic r_in_inop;
    logic r_out_valid;
    logic out_free;
    logic advance;

    rbt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rbt_update u_update (
        .i_cfg              (cfg),
        .i_state            (r_state),
        .i_cmd              (r_in_cmd),
        .i_radio_inoperable (r_in_inop),
        .o_result           (upd)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_state.count   <= 8'sd0;
            r_state.backoff <= rbt_pkg::RST_WAIT_INITIAL;
            r_state.lost    <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= upd.state;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_cmd  <= i_cmd;
            r_in_inop <= i_radio_inoperable;
        end
        if (advance) begin
            r_out <= upd;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_action        = r_out.action;
    assign o_sync_error    = r_out.state.lost;
    assign o_data_allowed  = r_out.data_allowed;
    assign o_countdown     = r_out.state.count;
    assign o_backoff_limit = r_out.state.backoff;

    `RBT_ASSERT_NOW(a_off_sets_error, i_clk, i_rst_n, o_out_valid && (o_action == rbt_pkg::ACT_OFF), o_sync_error, "radio off without sync error")
    `RBT_ASSERT_NOW(a_resync_count, i_clk, i_rst_n, o_out_valid && (o_action == rbt_pkg::ACT_RESYNC), o_countdown == rbt_pkg::COUNT_RESYNC, "resync listen with wrong countdown")
    `RBT_ASSERT_NOW(a_data_allowed, i_clk, i_rst_n, o_out_valid, o_data_allowed == (o_countdown > 8'sd0), "data flag disagrees with countdown")
    `RBT_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && o_in_stall, r_in_valid && $stable(r_in_cmd) && $stable(r_in_inop), "held input item lost")

endmodule

/* test/tb_resync_backoff_timer.sv */
// testbench for resync_backoff_timer: directed and random tick/sync traffic with
// idling and back-pressure, every result checked against an in-bench timer model
// depends on rbt_pkg and the resync_backoff_timer rtl
`timescale 1ns / 1ps

module tb_resync_backoff_timer;

    import rbt_pkg::*;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SYNC = 1'b1;
    localparam int   HOLD_LEN = 80;

    typedef struct packed {
        t_action           action;
        logic              sync_error;
        logic              data_allowed;
        logic signed [7:0] countdown;
        logic signed [7:0] backoff_limit;
    } t_timer_out;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   i_cmd = 1'b0;
    logic                   i_radio_inoperable = 1'b0;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [1:0]             o_action;
    logic                   o_sync_error;
    logic                   o_data_allowed;
    logic signed [7:0]      o_countdown;
    logic signed [7:0]      o_backoff_limit;
    logic                   o_cfg_ready;

    // timer model: registers and state
    logic [6:0]        cfg_sync_timeout;
    logic [6:0]        cfg_resync_window;
    logic signed [7:0] cfg_wait_initial;
    logic [6:0]        cfg_wait_step;
    logic signed [7:0] tmr_count;
    logic signed [7:0] tmr_backoff;
    logic              tmr_lost;

    t_timer_out expected_q[$];
    int         fail_count = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         hold_seq = 0;
    int         hold_seen = 0;
    int         hold_cycles = 0;

    resync_backoff_timer DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_cmd              (i_cmd),
        .i_radio_inoperable (i_radio_inoperable),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_action           (o_action),
        .o_sync_error       (o_sync_error),
        .o_data_allowed     (o_data_allowed),
        .o_countdown        (o_countdown),
        .o_backoff_limit    (o_backoff_limit),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // long receiver hold-off, started by bumping hold_seq
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_cycles <= HOLD_LEN;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= (hold_cycles != 0) ||
                       (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
    end

    function automatic t_timer_out step_timer(input logic cmd, input logic inop);
        t_timer_out r;
        int         c;
        int         bk;
        r.action = ACT_NONE;
        if (cmd == CMD_SYNC) begin
            tmr_count   = $signed({1'b0, cfg_sync_timeout});
            tmr_backoff = cfg_wait_initial;
            tmr_lost    = 1'b0;
        end else if (!inop) begin
            c  = int'(tmr_count) - 1;
            bk = int'(tmr_backoff);
            if (c < -128) begin
                c = 127;
            end
            if (c <= 0) begin
                if (c >= -1 || c < bk) begin
                    // back-off grows only while it stays at or above the floor
                    if (c < bk && bk >= -125 + int'(cfg_wait_step)) begin
                        bk = bk - int'(cfg_wait_step);
                    end
                    c = -1;
                    r.action = ACT_RESYNC;
                end else if (c <= -1 - int'(cfg_resync_window)) begin
                    tmr_lost = 1'b1;
                    r.action = ACT_OFF;
                end
            end
            tmr_count   = c[7:0];
            tmr_backoff = bk[7:0];
        end
        r.sync_error    = tmr_lost;
        r.data_allowed  = (tmr_count > 0);
        r.countdown     = tmr_count;
        r.backoff_limit = tmr_backoff;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic signed [7:0] want,
                                 input logic signed [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_timer_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                compare_field("action", want.action, o_action);
                compare_field("sync_error", want.sync_error, o_sync_error);
                compare_field("data_allowed", want.data_allowed, o_data_allowed);
                compare_field("countdown", want.countdown, o_countdown);
                compare_field("backoff_limit", want.backoff_limit, o_backoff_limit);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic inop);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid         <= 1'b1;
        i_cmd              <= cmd;
        i_radio_inoperable <= inop;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(step_timer(cmd, inop));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(CMD_TICK, 1'b0);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no re-raise
    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SYNC_TIMEOUT:  cfg_sync_timeout  = data[6:0];
            CFG_RESYNC_WINDOW: cfg_resync_window = data[6:0];
            CFG_WAIT_INITIAL:  cfg_wait_initial  = data;
            CFG_WAIT_STEP:     cfg_wait_step     = data[6:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [7:0] tmo, input logic [7:0] win,
                                 input logic [7:0] init, input logic [7:0] wstep);
        wait_idle();
        write_reg(CFG_SYNC_TIMEOUT, tmo);
        write_reg(CFG_RESYNC_WINDOW, win);
        write_reg(CFG_WAIT_INITIAL, init);
        write_reg(CFG_WAIT_STEP, wstep);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        // defaults after reset: ignored tick, resync, then radio off
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_SYNC, 1'b1);
        send_ticks(2);
        send_item(CMD_SYNC, 1'b0);
    endtask

    task automatic test_register_extremes();
        load_settings(8'd1, 8'd0, 8'hFE, 8'd1);
        send_item(CMD_SYNC, 1'b0);
        send_ticks(6);
        load_settings(8'd127, 8'd120, 8'h83, 8'd64);
        send_item(CMD_SYNC, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b1);
        // big step from a shallow limit
        load_settings(8'd1, 8'd0, 8'hFE, 8'd64);
        send_item(CMD_SYNC, 1'b0);
        send_ticks(5);
    endtask

    task automatic test_countdown_wrap();
        // limit at -128 is never passed, so after one resync the countdown runs down and wraps to +127
        load_settings(8'd0, 8'h7F, 8'h80, 8'd1);
        send_item(CMD_SYNC, 1'b0);
        send_ticks(132);
        // positive limit: every expiry resyncs and deepens the limit
        load_settings(8'd2, 8'd3, 8'h7F, 8'd7);
        send_item(CMD_SYNC, 1'b0);
        send_ticks(6);
    endtask

    task automatic load_random_settings();
        int tmo;
        int win;
        int mag;
        int wstep;
        tmo   = ($urandom_range(99) < 60) ? $urandom_range(1, 8) : $urandom_range(1, 127);
        win   = ($urandom_range(99) < 50) ? $urandom_range(0, 3) : $urandom_range(0, 120);
        mag   = ($urandom_range(99) < 30) ? $urandom_range(100, 125) : $urandom_range(2, 125);
        wstep = $urandom_range(1, 64);
        // top bit of the 7-bit registers is don't-care
        load_settings({1'($urandom_range(1)), 7'(tmo)}, {1'($urandom_range(1)), 7'(win)},
                      8'(-mag), {1'($urandom_range(1)), 7'(wstep)});
    endtask

    task automatic run_random_phase(input int items);
        int   done_cnt;
        int   run_len;
        logic inop;
        logic cmd;
        done_cnt = 0;
        load_random_settings();
        while (done_cnt < items) begin
            if ($urandom_range(99) < 85) begin
                // sync followed by a run of ticks
                send_item(CMD_SYNC, $urandom_range(99) < 20);
                done_cnt++;
                run_len = ($urandom_range(99) < 80) ? $urandom_range(1, 30)
                                                    : $urandom_range(30, 160);
                repeat (run_len) begin
                    inop = ($urandom_range(99) < 10);
                    send_item(CMD_TICK, inop);
                    done_cnt++;
                end
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    cmd  = ($urandom_range(99) < 30) ? CMD_SYNC : CMD_TICK;
                    inop = $urandom_range(1);
                    send_item(cmd, inop);
                    done_cnt++;
                end
            end
        end
    endtask

    task automatic test_random();
        run_random_phase(220);
        run_random_phase(220);
        tx_idle_pct = 50;
        rx_idle_pct = 26;
        run_random_phase(220);
        run_random_phase(220);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase(220);
        run_random_phase(220);
    endtask

    task automatic test_stall_fill();
        wait_idle();
        hold_seq <= hold_seq + 1;
        send_item(CMD_SYNC, 1'b0);
        repeat (20) send_item(CMD_TICK, $urandom_range(99) < 10);
    endtask

    initial begin
        cfg_sync_timeout  = RST_SYNC_TIMEOUT;
        cfg_resync_window = RST_RESYNC_WINDOW;
        cfg_wait_initial  = RST_WAIT_INITIAL;
        cfg_wait_step     = RST_WAIT_STEP;
        tmr_count         = '0;
        tmr_backoff       = RST_WAIT_INITIAL;
        tmr_lost          = 1'b0;
        tx_idle_pct       = 26;
        rx_idle_pct       = 50;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_countdown_wrap();
        test_random();
        test_stall_fill();
        wait_idle();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
